// ===== rtl/cat_line_number_filter_assert.svh =====
// assertion macros for the line number filter checker
`ifndef CAT_LINE_NUMBER_FILTER_ASSERT_SVH
`define CAT_LINE_NUMBER_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CATLNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CATLNF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/catlnf_pkg.sv =====
// shared types and constants of the line number filter
`timescale 1ns / 1ps
package catlnf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int NUM_W         = 4 * NUMBER_DIGITS;
  localparam int POS_W         = $clog2(NUMBER_DIGITS + 3);
  localparam int DIG_IDX_W     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 2;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_CTRL_OFS = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_MODE   = 3'd0,
    CFG_SQUEEZE_BLANK = 3'd1,
    CFG_SHOW_ENDS     = 3'd2,
    CFG_SHOW_TABS     = 3'd3,
    CFG_SHOW_CONTROL  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    NUM_NONE     = 2'd0,
    NUM_ALL      = 2'd1,
    NUM_NONBLANK = 2'd2
  } num_mode_e;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_control;
  } cfg_t;

  // one queued line step: optional number prefix and one or two body bytes
  typedef struct packed {
    logic                                has_num;
    logic [NUMBER_DIGITS-1:0][3:0]       digits;
    logic [NUMBER_DIGITS-1:0]            space;
    logic                                body_two;
    logic [7:0]                          b0;
    logic [7:0]                          b1;
  } desc_t;

endpackage

// ===== rtl/catlnf_fifo.sv =====
// two-entry descriptor queue between front and back end
`timescale 1ns / 1ps
module catlnf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  catlnf_pkg::desc_t    push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output catlnf_pkg::desc_t    head_o,
  output logic                 empty_o
);
  import catlnf_pkg::*;

  desc_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/catlnf_front.sv =====
// front end: line state, bcd line counter and classification of each input byte
`timescale 1ns / 1ps
module catlnf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  catlnf_pkg::cfg_t     cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 file_start_i,
  output logic                 push_o,
  output catlnf_pkg::desc_t    push_data_o,
  input  logic                 full_i
);
  import catlnf_pkg::*;

  localparam logic [NUM_W-1:0] LINE_ONE = NUM_W'(1);

  logic [NUMBER_DIGITS-1:0][3:0] line_q, line_d;
  logic                          after_nl_q, after_nl_d;
  logic [1:0]                    blank_run_q, blank_run_d;

  logic [NUMBER_DIGITS-1:0][3:0] line_cur, line_inc;
  logic                          after_cur;
  logic [1:0]                    blank_cur, blank_new;
  logic                          is_nl, squeezed, want_num, accept;
  logic                          all_nine, carry, zero_above;
  desc_t                         desc;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    line_cur  = file_start_i ? LINE_ONE : line_q;
    after_cur = file_start_i ? 1'b1 : after_nl_q;
    blank_cur = file_start_i ? 2'd0 : blank_run_q;
    is_nl     = (in_byte_i == CH_NL);

    if (is_nl && after_cur) begin
      blank_new = (blank_cur == 2'd3) ? 2'd3 : blank_cur + 2'd1;
    end else begin
      blank_new = 2'd0;
    end
    squeezed = cfg_i.squeeze_blank && (blank_new >= 2'd2);
    want_num = after_cur && ((cfg_i.number_mode == NUM_ALL) ||
                             ((cfg_i.number_mode == NUM_NONBLANK) && !is_nl));

    // saturating bcd increment
    all_nine = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      all_nine = all_nine && (line_cur[i] == 4'd9);
    end
    carry    = 1'b1;
    line_inc = line_cur;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (line_cur[i] >= 4'd9) begin
          line_inc[i] = 4'd0;
        end else begin
          line_inc[i] = line_cur[i] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (all_nine) begin
      line_inc = line_cur;
    end

    // leading zero blanking, lowest digit always printed
    zero_above = 1'b1;
    desc.space = '0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      zero_above    = zero_above && (line_cur[i] == 4'd0);
      desc.space[i] = zero_above && (i > 0);
    end
    desc.has_num = want_num;
    desc.digits  = line_cur;

    desc.body_two = 1'b0;
    desc.b0       = in_byte_i;
    desc.b1       = in_byte_i;
    if (is_nl) begin
      if (cfg_i.show_ends) begin
        desc.body_two = 1'b1;
        desc.b0       = CH_DOLLAR;
        desc.b1       = CH_NL;
      end
    end else if ((in_byte_i == CH_TAB) && cfg_i.show_tabs) begin
      desc.body_two = 1'b1;
      desc.b0       = CH_CARET;
      desc.b1       = CH_I;
    end else if ((in_byte_i < CH_SPACE) && (in_byte_i != CH_TAB) && cfg_i.show_control) begin
      desc.body_two = 1'b1;
      desc.b0       = CH_CARET;
      desc.b1       = in_byte_i + CH_CTRL_OFS;
    end

    line_d      = line_q;
    after_nl_d  = after_nl_q;
    blank_run_d = blank_run_q;
    if (accept) begin
      blank_run_d = blank_new;
      if (squeezed) begin
        line_d     = line_cur;
        after_nl_d = after_cur;
      end else begin
        line_d     = want_num ? line_inc : line_cur;
        after_nl_d = is_nl;
      end
    end
  end

  assign push_o      = accept && !squeezed;
  assign push_data_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= LINE_ONE;
      after_nl_q  <= 1'b1;
      blank_run_q <= 2'd0;
    end else begin
      line_q      <= line_d;
      after_nl_q  <= after_nl_d;
      blank_run_q <= blank_run_d;
    end
  end

endmodule

// ===== rtl/catlnf_back.sv =====
// back end: expands the queue head into output words, one per cycle while not stalled
`timescale 1ns / 1ps
module catlnf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  catlnf_pkg::desc_t    head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);
  import catlnf_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  logic [POS_W-1:0] body_start, last_pos, dig_pos;
  logic [3:0]       dig;
  logic [7:0]       cur_byte;
  logic             cur_last, load;

  always_comb begin
    body_start = head_i.has_num ? POS_W'(NUMBER_DIGITS + 1) : '0;
    last_pos   = body_start + POS_W'(head_i.body_two);
    dig_pos    = POS_W'(NUMBER_DIGITS - 1) - pos_q;
    dig        = head_i.digits[dig_pos[DIG_IDX_W-1:0]];
    if (dig > 4'd9) begin
      dig = 4'd9;
    end

    if (head_i.has_num && (pos_q < POS_W'(NUMBER_DIGITS))) begin
      cur_byte = head_i.space[dig_pos[DIG_IDX_W-1:0]] ? CH_SPACE : CH_ZERO + {4'd0, dig};
    end else if (head_i.has_num && (pos_q == POS_W'(NUMBER_DIGITS))) begin
      cur_byte = CH_TAB;
    end else if (pos_q == body_start) begin
      cur_byte = head_i.b0;
    end else begin
      cur_byte = head_i.b1;
    end
    cur_last = (pos_q == last_pos);

    load = !empty_i && (!out_valid_q || out_ready_i);

    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = cur_last;
      pos_d       = cur_last ? '0 : pos_q + 1'b1;
    end
  end

  assign pop_o       = load && cur_last;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

// ===== rtl/cat_line_number_filter.sv =====
// top level of the line number filter: config registers, front, queue, back
// Text filter in the manner of cat -n/-b/-s/-E/-T/-v: one input byte per word on the
// slave side, file start flag on tuser; zero to nine output bytes per input on the
// master side, tlast on the final byte of each input. An input that yields one byte
// passes at one word per cycle while the output is ready; one that yields n bytes
// (six-digit number prefix plus tab, dollar before newline, caret pairs) holds the
// output until all n are out, as the back end emits one byte per cycle while it is ready
// from the head of a two-entry queue. A squeezed blank line is accepted and yields
// nothing. Configuration is to be written through cfg_we_i, cfg_idx_i, cfg_wdata_i
// while the block is idle; the user must ensure this, as the block does not check it.
`timescale 1ns / 1ps
module cat_line_number_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [catlnf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [catlnf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // in_byte
  input  logic                             s_axis_tuser_i,  // file_start
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,  // out_byte
  output logic                             m_axis_tlast_o
);
  import catlnf_pkg::*;

  cfg_t  cfg_q, cfg_d;
  desc_t push_data, head;
  logic  push, full, pop, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUMBER_MODE:   cfg_d.number_mode   = cfg_wdata_i[1:0];
        CFG_SQUEEZE_BLANK: cfg_d.squeeze_blank = cfg_wdata_i[0];
        CFG_SHOW_ENDS:     cfg_d.show_ends     = cfg_wdata_i[0];
        CFG_SHOW_TABS:     cfg_d.show_tabs     = cfg_wdata_i[0];
        CFG_SHOW_CONTROL:  cfg_d.show_control  = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  catlnf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .file_start_i (s_axis_tuser_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  catlnf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  catlnf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== rtl/catlnf_checker.sv =====
// port-level checker of the line number filter and its bind
`timescale 1ns / 1ps
`include "cat_line_number_filter_assert.svh"
module catlnf_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tready_o,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [7:0]                       m_axis_tdata_o,
  input  logic                             m_axis_tlast_o
);

  // stalled output word is held
  `CATLNF_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled output word changed")

  // no output word right after reset release
  `CATLNF_ASSERT_IMP(a_out_idle_rst, $rose(rst_ni), !m_axis_tvalid_o, "output valid right after reset")

  // queue is empty after reset, so input side is ready
  `CATLNF_ASSERT_IMP(a_in_ready_rst, $rose(rst_ni), s_axis_tready_o, "input not ready after reset")

endmodule

bind cat_line_number_filter catlnf_checker u_catlnf_checker (.*);

// ===== tb/cat_line_number_filter_test.sv =====
// self-checking testbench of the line number filter with a byte-level scoreboard
`timescale 1ns / 1ps
module cat_line_number_filter_test;
  import catlnf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 220;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_word_t;

  class line_filter_board;
    logic [1:0]      number_mode;
    logic            squeeze_blank;
    logic            show_ends;
    logic            show_tabs;
    logic            show_control;
    logic [NUM_W-1:0] line_bcd;
    logic            at_line_start;
    logic [1:0]      blank_cnt;
    text_word_t      pending_text[$];
    int              errors;

    function new();
      number_mode   = NUM_NONE;
      squeeze_blank = 1'b0;
      show_ends     = 1'b0;
      show_tabs     = 1'b0;
      show_control  = 1'b0;
      errors        = 0;
      restart_lines();
    endfunction

    function void restart_lines();
      line_bcd      = NUM_W'(1);
      at_line_start = 1'b1;
      blank_cnt     = 2'd0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_NUMBER_MODE:   number_mode   = val;
        CFG_SQUEEZE_BLANK: squeeze_blank = val[0];
        CFG_SHOW_ENDS:     show_ends     = val[0];
        CFG_SHOW_TABS:     show_tabs     = val[0];
        CFG_SHOW_CONTROL:  show_control  = val[0];
        default: ;
      endcase
    endfunction

    function void advance_line();
      logic [3:0] d;
      if (line_bcd == {NUMBER_DIGITS{4'h9}}) return;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        d = line_bcd[4*i +: 4];
        if (d >= 4'd9) begin
          line_bcd[4*i +: 4] = 4'd0;
        end else begin
          line_bcd[4*i +: 4] = d + 4'd1;
          break;
        end
      end
    endfunction

    // predict the output bytes of one accepted input word
    function void note_byte(logic [7:0] b, logic fs);
      logic [7:0] text[$];
      logic       is_nl;
      logic       lead;
      logic [3:0] d;
      text_word_t w;
      is_nl = (b == CH_NL);
      if (fs) restart_lines();
      if (is_nl && at_line_start) begin
        if (blank_cnt < 2'd3) blank_cnt++;
      end else begin
        blank_cnt = 2'd0;
      end
      if (squeeze_blank && blank_cnt >= 2'd2) return;
      if (at_line_start &&
          (number_mode == NUM_ALL || (number_mode == NUM_NONBLANK && !is_nl))) begin
        lead = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
          d = line_bcd[4*i +: 4];
          if (lead && d == 4'd0 && i > 0) begin
            text.push_back(CH_SPACE);
          end else begin
            lead = 1'b0;
            text.push_back(CH_ZERO + ((d > 4'd9) ? 8'd9 : {4'd0, d}));
          end
        end
        text.push_back(CH_TAB);
        advance_line();
      end
      if (is_nl) begin
        if (show_ends) text.push_back(CH_DOLLAR);
        text.push_back(CH_NL);
      end else if (b == CH_TAB && show_tabs) begin
        text.push_back(CH_CARET);
        text.push_back(CH_I);
      end else if (b < CH_SPACE && b != CH_TAB && show_control) begin
        text.push_back(CH_CARET);
        text.push_back(b + CH_CTRL_OFS);
      end else begin
        text.push_back(b);
      end
      at_line_start = is_nl;
      foreach (text[i]) begin
        w.data = text[i];
        w.last = (i == text.size() - 1);
        pending_text.push_back(w);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      text_word_t w;
      if (pending_text.size() == 0) begin
        $error("unexpected output word: out_byte %h last %b", data, last);
        errors++;
        return;
      end
      w = pending_text.pop_front();
      if (data !== w.data) begin
        $error("out_byte expected %h actual %h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("last expected %b actual %b", w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_text.size();
    endfunction
  endclass

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic [7:0]            s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [7:0]            m_tdata;
  logic                  m_tlast;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  line_filter_board board = new();

  cat_line_number_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // outputs are stable from the falling edge up to the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_byte(m_tdata, m_tlast);
  end

  task automatic send_word(input logic [7:0] b, input logic fs);
    logic taken;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= fs;
    do begin
      @(negedge clk_i);
      taken = s_tready;
      if (taken) board.note_byte(b, fs);
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    // a squeezed line yields nothing, so let the pipeline empty
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic apply_config(input logic [1:0] mode, input logic [1:0] sq,
                              input logic [1:0] ends, input logic [1:0] tabs,
                              input logic [1:0] ctrl);
    write_reg(CFG_NUMBER_MODE, mode);
    write_reg(CFG_SQUEEZE_BLANK, sq);
    write_reg(CFG_SHOW_ENDS, ends);
    write_reg(CFG_SHOW_TABS, tabs);
    write_reg(CFG_SHOW_CONTROL, ctrl);
    write_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, 2'($urandom_range(3)));
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 38) return 8'($urandom_range(8'h21, 8'h7e));
    if (r < 46) return CH_SPACE;
    if (r < 70) return CH_NL;
    if (r < 77) return CH_TAB;
    if (r < 85) return 8'($urandom_range(31));
    if (r < 92) return 8'($urandom_range(8'h7f, 8'hff));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int sent;
    int seg;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct   = 34;
    recv_stall_pct = 78;

    // every option on, numbering all lines
    apply_config(NUM_ALL, 2'd1, 2'd1, 2'd1, 2'd1);
    send_word("A", 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h1f, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word("x", 1'b0);
    send_word(CH_NL, 1'b0);
    // blank lines right at a file start
    send_word(CH_NL, 1'b1);
    send_word(CH_NL, 1'b0);
    send_word(CH_SPACE, 1'b0);
    wait_idle();

    // non-blank numbering, raw tab with control display on
    apply_config(NUM_NONBLANK, 2'd2, 2'd0, 2'd2, 2'd3);
    send_word(CH_TAB, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word("z", 1'b0);
    wait_idle();

    // unused number mode, everything else off
    apply_config(2'd3, 2'd0, 2'd2, 2'd0, 2'd0);
    send_word(8'h1b, 1'b1);
    send_word(CH_NL, 1'b0);
    send_word(CH_NL, 1'b0);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent < RANDOM_WORDS / 3) begin
        send_gap_pct   = 34;
        recv_stall_pct = 78;
      end else if (sent < 2 * RANDOM_WORDS / 3) begin
        send_gap_pct   = 78;
        recv_stall_pct = 34;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      apply_config(2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)),
                   2'($urandom_range(3)), 2'($urandom_range(3)));
      seg = $urandom_range(15, 35);
      for (int i = 0; i < seg; i++) begin
        send_word(pick_byte(), ($urandom_range(99) < 4));
        sent++;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
